// ===== design/jgsl_pkg.sv =====
// ----------------------------------------------------------------------------
// jgsl_pkg
// Shared payload types and fixed constants of the joystick gaze controller.
// ----------------------------------------------------------------------------
package jgsl_pkg;

    // Converter resolution; the top reading is (1 << ADC_BITS) - 1.
    localparam int ADC_BITS = 12;

    typedef struct packed {
        logic [ADC_BITS-1:0] joy_x;
        logic [ADC_BITS-1:0] joy_y;
        logic                button;
    } t_in;

    typedef struct packed {
        logic [7:0] pan_angle;
        logic [7:0] tilt_angle;
        logic [7:0] lid_top_left;
        logic [7:0] lid_top_right;
        logic [7:0] lid_bottom_left;
        logic [7:0] lid_bottom_right;
        logic       blinking;
    } t_out;

    localparam logic [7:0] ANGLE_CENTER = 8'd90;

    // Lid poses: "closed" end of each lid servo, the other end is open.
    localparam logic [7:0] LID_HIGH = 8'd90;
    localparam logic [7:0] LID_LOW  = 8'd10;

    // Tilt window for the squint progress.
    localparam logic [7:0] TILT_LID_BASE = 8'd40;
    localparam logic [7:0] TILT_LID_TOP  = 8'd140;

    localparam logic [6:0]  SQUINT_FULL  = 7'd100;
    localparam logic [13:0] CLOSE_SCALE  = 14'd10000;
    // floor(m / 125) = (m * 8389) >> 20, exact for m <= 10000.
    localparam logic [13:0] RECIP_125    = 14'd8389;
    localparam int          RECIP_SHIFT  = 20;
    localparam logic [6:0]  LID_DIVISOR  = 7'd125;

    // Configuration register indexes.
    localparam logic [2:0] REG_DEADZONE = 3'd0;
    localparam logic [2:0] REG_CENTER   = 3'd1;
    localparam logic [2:0] REG_MAX_STEP = 3'd2;
    localparam logic [2:0] REG_PAN_MIN  = 3'd3;
    localparam logic [2:0] REG_PAN_MAX  = 3'd4;
    localparam logic [2:0] REG_TILT_MIN = 3'd5;
    localparam logic [2:0] REG_TILT_MAX = 3'd6;
    localparam logic [2:0] REG_SQUINT   = 3'd7;

endpackage

// ===== design/jgsl_axis_lane.sv =====
// ----------------------------------------------------------------------------
// jgsl_axis_lane
// One axis: deadzone test, interpolation setup and a restoring divider that
// retires one quotient bit per cycle, then the clamp to the axis limits.
// ----------------------------------------------------------------------------
module jgsl_axis_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [jgsl_pkg::ADC_BITS-1:0] i_p,
    input  logic [7:0]                    i_lo_end,
    input  logic [7:0]                    i_hi_end,
    input  logic [11:0]                   i_center,
    input  logic [10:0]                   i_deadzone,
    output logic                          o_done,
    output logic [7:0]                    o_target
);
    import jgsl_pkg::*;

    localparam int NUM_W = ADC_BITS + 10;
    localparam int DEN_W = ADC_BITS + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic signed [NUM_W-1:0] FULL = NUM_W'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic signed [NUM_W-1:0] C90  = NUM_W'(90);

    logic signed [NUM_W-1:0] s_p, s_c, s_dz, s_lo, s_hi, s_diff, s_mag;
    logic signed [NUM_W-1:0] s_den, s_num, s_den_abs, s_num_abs;
    logic                    bypass;

    logic                    r_busy, r_done, r_bypass, r_neg;
    logic [CNT_W-1:0]        r_cnt;
    logic [NUM_W-1:0]        r_quo;
    logic [DEN_W-1:0]        r_rem, r_den;
    logic [7:0]              r_lo, r_hi, r_target;

    logic [DEN_W:0]          rem_sh;
    logic                    q_bit;
    logic signed [NUM_W:0]   v;
    logic [7:0]              tgt;

    always_comb begin
        s_p    = NUM_W'(i_p);
        s_c    = NUM_W'(i_center);
        s_dz   = NUM_W'(i_deadzone);
        s_lo   = NUM_W'(i_lo_end);
        s_hi   = NUM_W'(i_hi_end);
        s_diff = s_p - s_c;
        s_mag  = s_diff[NUM_W-1] ? -s_diff : s_diff;
        if (s_p < s_c) begin
            s_den = s_c - s_dz;
            s_num = s_lo * s_den + s_p * (C90 - s_lo);
        end else begin
            s_den = FULL - s_c - s_dz;
            s_num = C90 * s_den + (s_p - s_c - s_dz) * (s_hi - C90);
        end
        s_den_abs = s_den[NUM_W-1] ? -s_den : s_den;
        s_num_abs = s_num[NUM_W-1] ? -s_num : s_num;
        bypass    = (s_mag < s_dz) || (s_den == '0);
    end

    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
        v      = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        if (r_bypass) begin
            tgt = ANGLE_CENTER;
        end else if (v < $signed({{(NUM_W-7){1'b0}}, r_lo})) begin
            tgt = r_lo;
        end else if (v > $signed({{(NUM_W-7){1'b0}}, r_hi})) begin
            tgt = r_hi;
        end else begin
            tgt = v[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bypass <= bypass;
            r_neg    <= s_den[NUM_W-1] ^ s_num[NUM_W-1];
            r_quo    <= s_num_abs;
            r_den    <= s_den_abs[DEN_W-1:0];
            r_rem    <= '0;
            r_lo     <= (i_lo_end < i_hi_end) ? i_lo_end : i_hi_end;
            r_hi     <= (i_lo_end < i_hi_end) ? i_hi_end : i_lo_end;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
        end
        if (r_busy && (r_cnt == '0)) begin
            r_target <= tgt;
        end
    end

    assign o_done   = r_done;
    assign o_target = r_target;

endmodule

// ===== design/jgsl_merge.sv =====
// ----------------------------------------------------------------------------
// jgsl_merge
// Merge the lane targets: slew-limit the stored gaze, then derive the four
// lid angles from the new tilt over three further steps.
// ----------------------------------------------------------------------------
module jgsl_merge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [7:0]       i_pan_tgt,
    input  logic [7:0]       i_tilt_tgt,
    input  logic [7:0]       i_max_step,
    input  logic [6:0]       i_squint,
    output logic [7:0]       o_pan_now,
    output logic [7:0]       o_tilt_now,
    output logic             o_done,
    output jgsl_pkg::t_out   o_res
);
    import jgsl_pkg::*;

    logic [7:0]  r_pan_now, r_tilt_now, n_pan_now, n_tilt_now;
    logic [6:0]  r_d, n_d, sqc, r_qt, r_qb;
    logic [13:0] r_mt, r_mb, rt, rb;
    logic [1:0]  r_step;
    logic        r_busy, r_done;
    t_out        r_res;
    logic [6:0]  ceil_t, ceil_b;

    function automatic logic [7:0] slew(input logic [7:0] now, input logic [7:0] tgt,
                                        input logic [7:0] stp);
        logic signed [9:0] d;
        logic signed [9:0] s;
        d = $signed({2'b00, tgt}) - $signed({2'b00, now});
        s = $signed({2'b00, stp});
        if (d > s)       return now + stp;
        else if (d < -s) return now - stp;
        else             return tgt;
    endfunction

    always_comb begin
        n_pan_now  = slew(r_pan_now, i_pan_tgt, i_max_step);
        n_tilt_now = slew(r_tilt_now, i_tilt_tgt, i_max_step);
        if (n_tilt_now < TILT_LID_BASE)     n_d = 7'd0;
        else if (n_tilt_now > TILT_LID_TOP) n_d = SQUINT_FULL;
        else                                n_d = 7'(n_tilt_now - TILT_LID_BASE);
        sqc    = (i_squint > SQUINT_FULL) ? SQUINT_FULL : i_squint;
        rt     = r_mt - 14'(r_qt) * 14'(LID_DIVISOR);
        rb     = r_mb - 14'(r_qb) * 14'(LID_DIVISOR);
        ceil_t = r_qt + 7'(rt != '0);
        ceil_b = r_qb + 7'(rb != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_now  <= ANGLE_CENTER;
            r_tilt_now <= ANGLE_CENTER;
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_step     <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_pan_now  <= n_pan_now;
                r_tilt_now <= n_tilt_now;
                r_busy     <= 1'b1;
                r_step     <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d <= n_d;
        end
        if (r_busy) begin
            case (r_step)
                2'd0: begin
                    r_mt <= CLOSE_SCALE - 14'(sqc) * 14'(SQUINT_FULL - r_d);
                    r_mb <= CLOSE_SCALE - 14'(sqc) * 14'(r_d);
                end
                2'd1: begin
                    r_qt <= 7'((28'(r_mt) * 28'(RECIP_125)) >> RECIP_SHIFT);
                    r_qb <= 7'((28'(r_mb) * 28'(RECIP_125)) >> RECIP_SHIFT);
                end
                2'd2: begin
                    r_res.pan_angle        <= r_pan_now;
                    r_res.tilt_angle       <= r_tilt_now;
                    r_res.lid_top_left     <= LID_HIGH - 8'(ceil_t);
                    r_res.lid_top_right    <= LID_LOW + 8'(r_qt);
                    r_res.lid_bottom_left  <= LID_LOW + 8'(r_qb);
                    r_res.lid_bottom_right <= LID_HIGH - 8'(ceil_b);
                    r_res.blinking         <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_pan_now  = r_pan_now;
    assign o_tilt_now = r_tilt_now;
    assign o_done     = r_done;
    assign o_res      = r_res;

endmodule

// ===== design/joystick_gaze_slew_lid_control.sv =====
// ----------------------------------------------------------------------------
// joystick_gaze_slew_lid_control
// Joystick-driven gaze with deadzone scaling, slew limiting and lid squint.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one joystick
//   sample per transfer. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns exactly one result per sample, in order.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
//   write it only while no sample is in flight.
//   Processing: a gaze sample runs both axis lanes side by side; each lane's
//   serial divider retires one quotient bit per cycle, ADC_BITS + 10 bits,
//   then the merge slew-limits the gaze and derives the lids before the
//   result register. A button sample goes straight to the result register.
//   Throughput: one sample at a time; the input is ready again once the
//   result has moved into the output register.
//   Reset: configuration returns to its defaults, both gaze angles to 90,
//   the output register empties.
//   Stall: a result waits in the output register while the receiver holds
//   i_out_ready low; the next sample is still taken and computed, and only
//   its hand-off waits for the register to free.
// ----------------------------------------------------------------------------
module joystick_gaze_slew_lid_control (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  jgsl_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output jgsl_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [11:0]     i_cfg_data
);
    import jgsl_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LANE  = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [10:0] r_deadzone;
    logic [11:0] r_center;
    logic [7:0]  r_max_step, r_pan_min, r_pan_max, r_tilt_min, r_tilt_max;
    logic [6:0]  r_squint;

    logic        in_xfer, lane_start, out_free;
    logic        pan_done, tilt_done, merge_done;
    logic [7:0]  pan_tgt, tilt_tgt, pan_now, tilt_now;
    t_out        merge_res, r_res, r_out_data;
    logic        r_out_valid;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign lane_start = in_xfer && !i_in_data.button;
    // The output register can take a result if empty or draining this cycle.
    assign out_free   = !r_out_valid || i_out_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= 11'd250;
            r_center   <= 12'd1830;
            r_max_step <= 8'd5;
            r_pan_min  <= 8'd60;
            r_pan_max  <= 8'd120;
            r_tilt_min <= 8'd60;
            r_tilt_max <= 8'd120;
            r_squint   <= 7'd60;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEADZONE: r_deadzone <= i_cfg_data[10:0];
                REG_CENTER:   r_center   <= i_cfg_data;
                REG_MAX_STEP: r_max_step <= i_cfg_data[7:0];
                REG_PAN_MIN:  r_pan_min  <= i_cfg_data[7:0];
                REG_PAN_MAX:  r_pan_max  <= i_cfg_data[7:0];
                REG_TILT_MIN: r_tilt_min <= i_cfg_data[7:0];
                REG_TILT_MAX: r_tilt_max <= i_cfg_data[7:0];
                REG_SQUINT:   r_squint   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    jgsl_axis_lane u_pan_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (lane_start),
        .i_p        (i_in_data.joy_x),
        .i_lo_end   (r_pan_min),
        .i_hi_end   (r_pan_max),
        .i_center   (r_center),
        .i_deadzone (r_deadzone),
        .o_done     (pan_done),
        .o_target   (pan_tgt)
    );

    jgsl_axis_lane u_tilt_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (lane_start),
        .i_p        (i_in_data.joy_y),
        .i_lo_end   (r_tilt_min),
        .i_hi_end   (r_tilt_max),
        .i_center   (r_center),
        .i_deadzone (r_deadzone),
        .o_done     (tilt_done),
        .o_target   (tilt_tgt)
    );

    // Lanes share one latency, so both finish in the same cycle.
    jgsl_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (pan_done && tilt_done),
        .i_pan_tgt  (pan_tgt),
        .i_tilt_tgt (tilt_tgt),
        .i_max_step (r_max_step),
        .i_squint   (r_squint),
        .o_pan_now  (pan_now),
        .o_tilt_now (tilt_now),
        .o_done     (merge_done),
        .o_res      (merge_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = i_in_data.button ? S_PUSH : S_LANE;
            end
            S_LANE: begin
                if (pan_done && tilt_done) n_state = S_MERGE;
            end
            S_MERGE: begin
                if (merge_done) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the pending result; a blink shows the held gaze and closed lids.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_data.button) begin
            r_res.pan_angle        <= pan_now;
            r_res.tilt_angle       <= tilt_now;
            r_res.lid_top_left     <= LID_HIGH;
            r_res.lid_top_right    <= LID_LOW;
            r_res.lid_bottom_left  <= LID_LOW;
            r_res.lid_bottom_right <= LID_HIGH;
            r_res.blinking         <= 1'b1;
        end else if (r_state == S_MERGE && merge_done) begin
            r_res <= merge_res;
        end
        if (r_state == S_PUSH && out_free) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/jgsl_checker.sv =====
// ----------------------------------------------------------------------------
// jgsl_checker
// Port-level checks of the joystick gaze controller, bound to the top level.
// ----------------------------------------------------------------------------
module jgsl_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input jgsl_pkg::t_in   i_in_data,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input jgsl_pkg::t_out  o_out_data
);
    import jgsl_pkg::*;

    // A held result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A held result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // One sample at a time: a transfer closes the input for the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // A blink result always carries the closed lid pose.
    a_blink_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.blinking |->
            o_out_data.lid_top_left == LID_HIGH && o_out_data.lid_top_right == LID_LOW &&
            o_out_data.lid_bottom_left == LID_LOW && o_out_data.lid_bottom_right == LID_HIGH)
        else $error("blink pose wrong");

endmodule

bind joystick_gaze_slew_lid_control jgsl_checker u_jgsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
